>>> src/bit_sliced_add_sub_compare_defines.svh
// Assertion macros shared by the bit-sliced add/sub/compare checker.
`ifndef BIT_SLICED_ADD_SUB_COMPARE_DEFINES_SVH
`define BIT_SLICED_ADD_SUB_COMPARE_DEFINES_SVH

// Implication checked on clk, off during reset.
`define BSASC_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bsasc: implication check failed");

// Condition that must hold in the cycle after reset is seen.
`define BSASC_ASSERT_AFTER_RST(label, cons) \
  label: assert property (@(posedge clk) rst |=> (cons)) \
    else $error("bsasc: post-reset check failed");

// A stalled valid stays up.
`define BSASC_ASSERT_HOLD(label, vld, rdy) \
  label: assert property (@(posedge clk) disable iff (rst) ((vld) && !(rdy)) |=> (vld)) \
    else $error("bsasc: valid dropped while stalled");

`endif

>>> src/bsasc_pkg.sv
// Shared types and constants for the bit-sliced add/sub/compare engine.
package bsasc_pkg;

  localparam int LANES  = 64;
  localparam int WORD_W = 64;
  localparam int CMD_W  = 3;
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [WORD_W-1:0] LANE_MASK = {WORD_W{1'b1}} >> (WORD_W - LANES);

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD = 3'd0,
    CMD_SUB = 3'd1,
    CMD_LT  = 3'd2,
    CMD_GT  = 3'd3,
    CMD_LE  = 3'd4,
    CMD_GE  = 3'd5,
    CMD_EQ  = 3'd6,
    CMD_NE  = 3'd7
  } cmd_t;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              last;
  } result_t;

  // Up to two results per request; v1 only with v0.
  typedef struct packed {
    logic    v0;
    logic    v1;
    result_t r0;
    result_t r1;
  } push_t;

endpackage

>>> src/bsasc_req_if.sv
// Request channel: one bit slice of each operand plus command.
interface bsasc_req_if;
  logic                          valid;
  logic                          ready;
  logic [bsasc_pkg::CMD_W-1:0]   cmd;
  logic [bsasc_pkg::WORD_W-1:0]  a_slice;
  logic [bsasc_pkg::WORD_W-1:0]  b_slice;
  logic                          last_slice;

  modport source (output valid, cmd, a_slice, b_slice, last_slice, input ready);
  modport sink   (input valid, cmd, a_slice, b_slice, last_slice, output ready);
endinterface

>>> src/bsasc_rsp_if.sv
// Result channel: result slice or bitmap plus final marker.
interface bsasc_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [bsasc_pkg::WORD_W-1:0]  result_word;
  logic                          result_last;

  modport source (output valid, result_word, result_last, input ready);
  modport sink   (input valid, result_word, result_last, output ready);
endinterface

>>> src/bit_sliced_add_sub_compare.sv
// Top level of the bit-sliced add/sub/compare engine.
// Usage:
//   req carries one bit slice of A and B per request (bit p = row position p),
//   a command and last_slice. Add/sub and lt/gt/le/ge stream slices LSB
//   first; eq/ne in any order. Pad the shorter operand with zeros.
//   rsp gives: add -> one sum slice per request plus a carry slice after the
//   last one; sub -> one difference slice per request, result_last on the
//   last; comparisons -> one bitmap with result_last on the last request.
//   Order: a request is registered in the input register, then its results
//   are written into the result queue that drives rsp; the carry slice of
//   an add follows its last sum slice in the queue.
//   Throughput: one request per cycle while the result queue has room; set
//   by the carry and accumulator loop in the slice datapath. An add's last
//   slice yields two results, so rsp drains at one per cycle while ready.
//   Reset (rst, synchronous) clears the accumulators and empties the result
//   queue. The accumulators clear after every last slice.
//   When rsp stalls, results wait in a four-entry queue; the input register
//   holds its request until the queue has room for two results, and req.ready
//   drops only then.
module bit_sliced_add_sub_compare (
  input  logic         clk,
  input  logic         rst,
  bsasc_req_if.sink    req,
  bsasc_rsp_if.source  rsp
);

  logic                          s1_valid;
  logic [bsasc_pkg::CMD_W-1:0]   s1_cmd;
  logic [bsasc_pkg::WORD_W-1:0]  s1_a;
  logic [bsasc_pkg::WORD_W-1:0]  s1_b;
  logic                          s1_last;
  logic                          has_room;
  logic                          s1_fire;
  logic                          req_take;
  bsasc_pkg::push_t              push;

  assign s1_fire   = s1_valid && has_room;
  assign req.ready = !s1_valid || s1_fire;
  assign req_take  = req.valid && req.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_take) begin
      s1_cmd  <= req.cmd;
      s1_a    <= req.a_slice;
      s1_b    <= req.b_slice;
      s1_last <= req.last_slice;
    end
  end

  bsasc_core u_core (
    .clk        (clk),
    .rst        (rst),
    .fire       (s1_fire),
    .cmd        (s1_cmd),
    .a_slice    (s1_a),
    .b_slice    (s1_b),
    .last_slice (s1_last),
    .push       (push)
  );

  bsasc_out_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .has_room (has_room),
    .rsp      (rsp)
  );

endmodule

>>> src/bsasc_core.sv
// Per-lane slice datapath: carry/borrow and comparison accumulators.
module bsasc_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          fire,
  input  logic [bsasc_pkg::CMD_W-1:0]   cmd,
  input  logic [bsasc_pkg::WORD_W-1:0]  a_slice,
  input  logic [bsasc_pkg::WORD_W-1:0]  b_slice,
  input  logic                          last_slice,
  output bsasc_pkg::push_t              push
);

  logic [bsasc_pkg::WORD_W-1:0] carry_or_borrow, carry_or_borrow_next;
  logic [bsasc_pkg::WORD_W-1:0] less_acc, greater_acc;
  logic [bsasc_pkg::WORD_W-1:0] a_any_acc, b_any_acc, diff_acc;

  logic [bsasc_pkg::WORD_W-1:0] a, b, x, lt, gt, anz, bnz, dif, eq, bitmap;
  bsasc_pkg::cmd_t              op;

  always_comb begin
    op  = bsasc_pkg::cmd_t'(cmd);
    a   = a_slice & bsasc_pkg::LANE_MASK;
    b   = b_slice & bsasc_pkg::LANE_MASK;
    x   = a ^ b;
    lt  = ((b | less_acc) & ~a) | (b & less_acc);
    gt  = ((a | greater_acc) & ~b) | (a & greater_acc);
    anz = a_any_acc | a;
    bnz = b_any_acc | b;
    dif = diff_acc | x;
    eq  = anz & bnz & ~dif;

    case (op)
      bsasc_pkg::CMD_LT: bitmap = lt;
      bsasc_pkg::CMD_GT: bitmap = gt;
      bsasc_pkg::CMD_LE: bitmap = lt | eq;
      bsasc_pkg::CMD_GE: bitmap = gt | eq;
      bsasc_pkg::CMD_EQ: bitmap = eq;
      default:           bitmap = anz & bnz & dif;
    endcase

    carry_or_borrow_next = carry_or_borrow;
    push.v0      = 1'b0;
    push.v1      = 1'b0;
    push.r0.word = bitmap;
    push.r0.last = 1'b1;
    push.r1.word = carry_or_borrow_next;
    push.r1.last = 1'b1;

    case (op)
      bsasc_pkg::CMD_ADD: begin
        carry_or_borrow_next = (a & b) | (x & carry_or_borrow);
        push.v0      = fire;
        push.v1      = fire & last_slice;
        push.r0.word = x ^ carry_or_borrow;
        push.r0.last = 1'b0;
        push.r1.word = carry_or_borrow_next;
      end
      bsasc_pkg::CMD_SUB: begin
        carry_or_borrow_next = ((~a & b) | (~x & carry_or_borrow)) & bsasc_pkg::LANE_MASK;
        push.v0      = fire;
        push.r0.word = x ^ carry_or_borrow;
        push.r0.last = last_slice;
      end
      default: begin
        push.v0 = fire & last_slice;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst || (fire && last_slice)) begin
      carry_or_borrow <= '0;
      less_acc        <= '0;
      greater_acc     <= '0;
      a_any_acc       <= '0;
      b_any_acc       <= '0;
      diff_acc        <= '0;
    end else if (fire) begin
      carry_or_borrow <= carry_or_borrow_next;
      less_acc        <= lt;
      greater_acc     <= gt;
      a_any_acc       <= anz;
      b_any_acc       <= bnz;
      diff_acc        <= dif;
    end
  end

endmodule

>>> src/bsasc_out_queue.sv
// Small result queue: takes up to two results a cycle, gives one while rsp is ready.
module bsasc_out_queue (
  input  logic                          clk,
  input  logic                          rst,
  input  bsasc_pkg::push_t              push,
  output logic                          has_room,
  bsasc_rsp_if.source                   rsp
);

  bsasc_pkg::result_t               mem [bsasc_pkg::QDEPTH];
  logic [bsasc_pkg::QPTR_W-1:0]     head, tail;
  logic [bsasc_pkg::QCNT_W-1:0]     count, count_next;
  logic                             pop;
  logic [bsasc_pkg::QPTR_W-1:0]     tail_plus1;

  // room for two results regardless of this cycle's pop
  assign has_room   = count <= bsasc_pkg::QCNT_W'(bsasc_pkg::QDEPTH - 2);
  assign pop        = rsp.valid && rsp.ready;
  assign tail_plus1 = tail + 1'b1;

  assign rsp.valid       = count != '0;
  assign rsp.result_word = mem[head].word;
  assign rsp.result_last = mem[head].last;

  always_comb begin
    count_next = count + bsasc_pkg::QCNT_W'(push.v0) + bsasc_pkg::QCNT_W'(push.v1)
               - bsasc_pkg::QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.v0) begin
      mem[tail] <= push.r0;
    end
    if (push.v1) begin
      mem[tail_plus1] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      count <= count_next;
      if (pop) begin
        head <= head + 1'b1;
      end
      if (push.v1) begin
        tail <= tail + 2'd2;
      end else if (push.v0) begin
        tail <= tail_plus1;
      end
    end
  end

endmodule

>>> src/bsasc_checker.sv
// Port-level checks for the bit-sliced add/sub/compare engine, with bind.
`include "bit_sliced_add_sub_compare_defines.svh"

module bsasc_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          req_valid,
  input logic                          req_ready,
  input logic                          rsp_valid,
  input logic                          rsp_ready,
  input logic [bsasc_pkg::WORD_W-1:0]  rsp_word
);

  `BSASC_ASSERT_AFTER_RST(a_rst_rsp_idle, !rsp_valid)
  `BSASC_ASSERT_AFTER_RST(a_rst_req_ready, req_ready)
  `BSASC_ASSERT_IMPLY(a_high_lanes_zero, rsp_valid, (rsp_word & ~bsasc_pkg::LANE_MASK) == '0)
  `BSASC_ASSERT_HOLD(a_rsp_hold, rsp_valid, rsp_ready)

endmodule

bind bit_sliced_add_sub_compare bsasc_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .rsp_word  (rsp.result_word)
);
